FILE: sv/xec_pkg.sv
// Types, entity tables and constants shared by the XML entity codec.
`timescale 1ns / 1ps
`default_nettype none
package xec_pkg;

  localparam int EntCount = 5;
  localparam int HoldMax  = 5;
  localparam int ListMax  = 6;

  localparam logic       MODE_DECODE = 1'b0;
  localparam logic       MODE_ENCODE = 1'b1;

  localparam logic [7:0] CH_AMP  = 8'h26;
  localparam logic [7:0] CH_LT   = 8'h3c;
  localparam logic [7:0] CH_GT   = 8'h3e;
  localparam logic [7:0] CH_QUOT = 8'h22;

  localparam logic [EntCount-1:0] ALL_MASK = '1;

  // entity order: amp, lt, gt, quot, apos
  localparam logic [7:0] ENT_TEXT [0:EntCount-1][0:ListMax-1] = '{
    '{8'h26, 8'h61, 8'h6d, 8'h70, 8'h3b, 8'h00},
    '{8'h26, 8'h6c, 8'h74, 8'h3b, 8'h00, 8'h00},
    '{8'h26, 8'h67, 8'h74, 8'h3b, 8'h00, 8'h00},
    '{8'h26, 8'h71, 8'h75, 8'h6f, 8'h74, 8'h3b},
    '{8'h26, 8'h61, 8'h70, 8'h6f, 8'h73, 8'h3b}
  };
  localparam logic [2:0] ENT_LEN  [0:EntCount-1] = '{3'd5, 3'd4, 3'd4, 3'd6, 3'd6};
  localparam logic [7:0] ENT_CHAR [0:EntCount-1] = '{8'h26, 8'h3c, 8'h3e, 8'h22, 8'h27};

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last;
  } req_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
  } rsp_item_t;

  typedef struct packed {
    logic [2:0]               count;
    logic                     last;
    logic [ListMax-1:0][7:0]  bytes;
  } result_list_t;

endpackage
`default_nettype wire

FILE: sv/xml_entity_codec.sv
// Top level of the streaming XML entity codec.
// Channels: req carries one text byte and its end-of-string flag per beat;
// rsp carries one converted byte per beat with out_last on the final byte
// of a string. Both use valid/stall; cfg is a valid/ready write of the mode
// bit (0 decodes entities, 1 encodes special characters), always ready.
// A cfg write discards any partial entity; write it only while idle.
// A result appears on rsp in the cycle after its byte is taken.
// Throughput: one req beat per cycle while rsp is not stalled and each
// byte yields at most one result. A byte that expands to n results
// (up to six: an encoded entity or a flushed partial entity plus the new
// byte) holds req stalled until the result register has sent n-1 of
// them, so the rsp beat rate bounds the block at one output byte per
// cycle. Bytes that only extend a partial entity yield no result.
// Reset clears the mode to decode, drops any held bytes and empties the
// result register. While rsp is stalled the current byte holds, and req
// stalls once the result register cannot be freed in that cycle.
`timescale 1ns / 1ps
`default_nettype none
module xml_entity_codec (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                req_valid,
  output logic                     req_stall,
  input  wire xec_pkg::req_item_t  req_data,
  output logic                     rsp_valid,
  input  wire logic                rsp_stall,
  output xec_pkg::rsp_item_t       rsp_data,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic                cfg_data
);

  logic                   can_load;
  logic                   take;
  xec_pkg::result_list_t  list;

  assign cfg_ready = 1'b1;
  assign req_stall = !can_load;
  assign take      = req_valid && can_load;

  xec_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_valid && cfg_ready),
    .cfg_mode  (cfg_data),
    .take      (take),
    .req       (req_data),
    .list      (list)
  );

  xec_drain u_drain (
    .clk       (clk),
    .rst       (rst),
    .load      (take),
    .list      (list),
    .can_load  (can_load),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_data  (rsp_data)
  );

endmodule
`default_nettype wire

FILE: sv/xec_core.sv
// Codec state and single-pass conversion of one byte into a result list.
`timescale 1ns / 1ps
`default_nettype none
module xec_core (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_write,
  input  wire logic                  cfg_mode,
  input  wire logic                  take,
  input  wire xec_pkg::req_item_t    req,
  output xec_pkg::result_list_t      list
);

  logic                          mode;
  logic [2:0]                    held_count;
  logic [2:0]                    held_count_next;
  logic [7:0]                    held_bytes [0:xec_pkg::HoldMax-1];
  logic [7:0]                    held_bytes_next [0:xec_pkg::HoldMax-1];
  logic [xec_pkg::EntCount-1:0]  candidate_mask;
  logic [xec_pkg::EntCount-1:0]  candidate_mask_next;

  logic [xec_pkg::EntCount-1:0]  next_mask;
  logic [xec_pkg::ListMax-1:0][7:0] fill;
  logic                          done;
  logic [7:0]                    hit_char;
  logic                          fresh_hold;
  logic [7:0]                    b;

  always_comb begin
    b          = req.data_byte;
    fresh_hold = (b == xec_pkg::CH_AMP) && !req.last;

    for (int j = 0; j < xec_pkg::ListMax; j++) begin
      if (j < xec_pkg::HoldMax && 3'(j) < held_count) begin
        fill[j] = held_bytes[j];
      end else begin
        fill[j] = b;
      end
    end

    done      = 1'b0;
    hit_char  = '0;
    next_mask = '0;
    for (int k = 0; k < xec_pkg::EntCount; k++) begin
      if (candidate_mask[k] && xec_pkg::ENT_LEN[k] > held_count &&
          xec_pkg::ENT_TEXT[k][held_count] == b) begin
        if (xec_pkg::ENT_LEN[k] == held_count + 3'd1) begin
          if (!done) begin
            hit_char = xec_pkg::ENT_CHAR[k];
          end
          done = 1'b1;
        end else begin
          next_mask[k] = 1'b1;
        end
      end
    end
  end

  always_comb begin
    list                = '0;
    list.last           = req.last;
    held_count_next     = held_count;
    candidate_mask_next = candidate_mask;
    held_bytes_next     = held_bytes;

    if (mode == xec_pkg::MODE_ENCODE) begin
      case (b)
        xec_pkg::CH_AMP: begin
          list.count = 3'd5;
          for (int j = 0; j < xec_pkg::ListMax; j++) list.bytes[j] = xec_pkg::ENT_TEXT[0][j];
        end
        xec_pkg::CH_LT: begin
          list.count = 3'd4;
          for (int j = 0; j < xec_pkg::ListMax; j++) list.bytes[j] = xec_pkg::ENT_TEXT[1][j];
        end
        xec_pkg::CH_GT: begin
          list.count = 3'd4;
          for (int j = 0; j < xec_pkg::ListMax; j++) list.bytes[j] = xec_pkg::ENT_TEXT[2][j];
        end
        xec_pkg::CH_QUOT: begin
          list.count = 3'd6;
          for (int j = 0; j < xec_pkg::ListMax; j++) list.bytes[j] = xec_pkg::ENT_TEXT[3][j];
        end
        default: begin
          list.count    = 3'd1;
          list.bytes[0] = b;
        end
      endcase
    end else if (held_count == 3'd0) begin
      if (fresh_hold) begin
        held_bytes_next[0]  = b;
        held_count_next     = 3'd1;
        candidate_mask_next = xec_pkg::ALL_MASK;
      end else begin
        list.count    = 3'd1;
        list.bytes[0] = b;
      end
    end else if (done) begin
      list.count          = 3'd1;
      list.bytes[0]       = hit_char;
      held_count_next     = 3'd0;
      candidate_mask_next = '0;
    end else if (next_mask != '0 && held_count < 3'(xec_pkg::HoldMax)) begin
      if (req.last) begin
        list.count          = held_count + 3'd1;
        list.bytes          = fill;
        held_count_next     = 3'd0;
        candidate_mask_next = '0;
      end else begin
        held_bytes_next[held_count] = b;
        held_count_next             = held_count + 3'd1;
        candidate_mask_next         = next_mask;
      end
    end else begin
      list.bytes = fill;
      if (fresh_hold) begin
        list.count          = held_count;
        held_bytes_next[0]  = b;
        held_count_next     = 3'd1;
        candidate_mask_next = xec_pkg::ALL_MASK;
      end else begin
        list.count          = held_count + 3'd1;
        held_count_next     = 3'd0;
        candidate_mask_next = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode           <= xec_pkg::MODE_DECODE;
      held_count     <= '0;
      candidate_mask <= '0;
    end else if (cfg_write) begin
      mode           <= cfg_mode;
      held_count     <= '0;
      candidate_mask <= '0;
    end else if (take) begin
      held_count     <= held_count_next;
      candidate_mask <= candidate_mask_next;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      held_bytes <= held_bytes_next;
    end
  end

endmodule
`default_nettype wire

FILE: sv/xec_drain.sv
// Result register that sends one converted byte per beat.
`timescale 1ns / 1ps
`default_nettype none
module xec_drain (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   load,
  input  wire xec_pkg::result_list_t  list,
  output logic                        can_load,
  output logic                        rsp_valid,
  input  wire logic                   rsp_stall,
  output xec_pkg::rsp_item_t          rsp_data
);

  logic [2:0]                           count;
  logic                                 last_flag;
  logic [xec_pkg::ListMax-1:0][7:0]     bytes;
  logic                                 sent;

  assign rsp_valid         = (count != 3'd0);
  assign sent              = rsp_valid && !rsp_stall;
  assign can_load          = (count == 3'd0) || (count == 3'd1 && !rsp_stall);
  assign rsp_data.out_byte = bytes[0];
  assign rsp_data.out_last = last_flag && (count == 3'd1);

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (load) begin
      count <= list.count;
    end else if (sent) begin
      count <= count - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      bytes     <= list.bytes;
      last_flag <= list.last;
    end else if (sent) begin
      bytes <= {8'h00, bytes[xec_pkg::ListMax-1:1]};
    end
  end

endmodule
`default_nettype wire

FILE: bench/xml_entity_codec_test.sv
// Self-checking bench for the XML entity codec: scripted and random text bytes in both modes.
`timescale 1ns / 1ps
module xml_entity_codec_test;

  localparam int ENTITIES    = 5;
  localparam int ENCODED     = 4;
  localparam int HOLD_SLOTS  = 5;
  localparam int SETTLE      = 4;
  localparam int PHASES      = 4;
  localparam int PHASE_ITEMS = 20;
  localparam int HOLD_AT     = 50;
  localparam int HOLD_CYCLES = 80;
  localparam int LIMIT_NS    = 400000;

  typedef enum logic {ROW_BYTE, ROW_MODE} row_kind_t;

  typedef struct packed {
    row_kind_t           kind;
    logic [7:0]          b;
    logic                eos;
    logic                typed;
    xec_pkg::rsp_item_t  want;
  } script_row_t;

  localparam int SCRIPT_ROWS = 30;

  logic               clk;
  logic               rst;
  logic               req_valid;
  logic               req_stall;
  xec_pkg::req_item_t req_data;
  logic               rsp_valid;
  logic               rsp_stall;
  xec_pkg::rsp_item_t rsp_data;
  logic               cfg_valid;
  logic               cfg_ready;
  logic               cfg_data;

  string      entity_spelling [ENTITIES] = '{"&amp;", "&lt;", "&gt;", "&quot;", "&apos;"};
  logic [7:0] entity_glyph    [ENTITIES] = '{"&", "<", ">", "\"", "'"};

  script_row_t script [SCRIPT_ROWS] = '{
    '{ROW_BYTE, "A",   1'b0, 1'b1, '{"A",   1'b0}},
    '{ROW_BYTE, 8'hff, 1'b0, 1'b1, '{8'hff, 1'b0}},
    '{ROW_BYTE, 8'h01, 1'b1, 1'b1, '{8'h01, 1'b1}},
    '{ROW_BYTE, "&",   1'b0, 1'b0, '0},
    '{ROW_BYTE, "l",   1'b0, 1'b0, '0},
    '{ROW_BYTE, "t",   1'b0, 1'b0, '0},
    '{ROW_BYTE, ";",   1'b0, 1'b1, '{"<",   1'b0}},
    '{ROW_BYTE, "&",   1'b0, 1'b0, '0},
    '{ROW_BYTE, "a",   1'b0, 1'b0, '0},
    '{ROW_BYTE, "p",   1'b0, 1'b0, '0},
    '{ROW_BYTE, "o",   1'b0, 1'b0, '0},
    '{ROW_BYTE, "s",   1'b0, 1'b0, '0},
    '{ROW_BYTE, ";",   1'b1, 1'b1, '{"'",   1'b1}},
    '{ROW_BYTE, "&",   1'b0, 1'b0, '0},
    '{ROW_BYTE, "a",   1'b0, 1'b0, '0},
    '{ROW_BYTE, "m",   1'b0, 1'b0, '0},
    '{ROW_BYTE, "x",   1'b0, 1'b0, '0},
    '{ROW_BYTE, "&",   1'b0, 1'b0, '0},
    '{ROW_BYTE, "q",   1'b1, 1'b0, '0},
    '{ROW_BYTE, "&",   1'b1, 1'b1, '{"&",   1'b1}},
    '{ROW_BYTE, 8'h00, 1'b0, 1'b1, '{8'h00, 1'b0}},
    '{ROW_BYTE, "&",   1'b0, 1'b0, '0},
    '{ROW_BYTE, "a",   1'b0, 1'b0, '0},
    '{ROW_MODE, {7'd0, xec_pkg::MODE_ENCODE}, 1'b0, 1'b0, '0},
    '{ROW_BYTE, "&",   1'b0, 1'b0, '0},
    '{ROW_BYTE, "<",   1'b0, 1'b0, '0},
    '{ROW_BYTE, ">",   1'b0, 1'b0, '0},
    '{ROW_BYTE, "\"",  1'b0, 1'b0, '0},
    '{ROW_BYTE, "'",   1'b1, 1'b1, '{"'",   1'b1}},
    '{ROW_MODE, {7'd0, xec_pkg::MODE_DECODE}, 1'b0, 1'b0, '0}
  };

  logic               codec_mode;
  int                 held_n;
  logic [7:0]         held_text [HOLD_SLOTS];
  logic [4:0]         live_entities;
  xec_pkg::rsp_item_t step_bytes [$];
  xec_pkg::rsp_item_t due_bytes [$];

  int items_sent;
  int beats;
  int mode_writes;
  int mismatches;
  int hold_left;
  bit held_once;

  xml_entity_codec dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req_data  (req_data),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_data  (rsp_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #LIMIT_NS;
    $display("FAILURE");
    $finish;
  end

  function automatic void put_byte(input logic [7:0] b);
    xec_pkg::rsp_item_t r;
    r.out_byte = b;
    r.out_last = 1'b0;
    step_bytes.push_back(r);
  endfunction

  function automatic void flush_held();
    for (int i = 0; i < held_n; i++) put_byte(held_text[i]);
    held_n = 0;
    live_entities = '0;
  endfunction

  function automatic void take_fresh(input logic [7:0] b, input logic eos);
    if (b == "&" && !eos) begin
      held_text[0] = b;
      held_n = 1;
      live_entities = '1;
    end else begin
      put_byte(b);
    end
  endfunction

  // Produce the converted bytes for one accepted input byte.
  function automatic void convert_byte(input logic [7:0] b, input logic eos);
    logic [4:0] still;
    int         hit;
    step_bytes.delete();
    if (codec_mode == xec_pkg::MODE_ENCODE) begin
      hit = -1;
      for (int k = 0; k < ENCODED; k++) if (hit < 0 && entity_glyph[k] == b) hit = k;
      if (hit >= 0) begin
        for (int i = 0; i < entity_spelling[hit].len(); i++) put_byte(entity_spelling[hit][i]);
      end else begin
        put_byte(b);
      end
    end else if (held_n == 0) begin
      take_fresh(b, eos);
    end else begin
      still = '0;
      hit = -1;
      for (int k = 0; k < ENTITIES; k++) begin
        if (hit < 0 && live_entities[k] && entity_spelling[k].len() > held_n &&
            entity_spelling[k][held_n] == b) begin
          if (entity_spelling[k].len() == held_n + 1) hit = k;
          else still[k] = 1'b1;
        end
      end
      if (hit >= 0) begin
        held_n = 0;
        live_entities = '0;
        put_byte(entity_glyph[hit]);
      end else if (still != '0 && held_n < HOLD_SLOTS) begin
        held_text[held_n] = b;
        held_n++;
        live_entities = still;
        if (eos) flush_held();
      end else begin
        flush_held();
        take_fresh(b, eos);
      end
    end
    if (eos && step_bytes.size() > 0) step_bytes[step_bytes.size() - 1].out_last = 1'b1;
  endfunction

  task automatic wait_idle();
    req_valid <= 1'b0;
    while (due_bytes.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_mode(input logic m);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_data <= m;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    codec_mode = m;
    held_n = 0;
    live_entities = '0;
    mode_writes++;
  endtask

  task automatic send_byte(input logic [7:0] b, input logic eos, input logic typed,
                           input xec_pkg::rsp_item_t want);
    int gap;
    gap = 0;
    if ((items_sent < 60 || items_sent >= 95) && $urandom_range(99) < 9)
      gap = 1;
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    req_data <= '{data_byte: b, last: eos};
    do @(posedge clk); while (req_stall);
    convert_byte(b, eos);
    if (typed) due_bytes.push_back(want);
    else foreach (step_bytes[i]) due_bytes.push_back(step_bytes[i]);
    items_sent++;
  endtask

  // Build one string: entities, their prefixes and plain bytes; in encode mode glyphs and bytes.
  task automatic send_string();
    logic [7:0] text [$];
    int         segs;
    int         pick;
    int         k;
    int         cut;
    segs = $urandom_range(1, 4);
    for (int s = 0; s < segs; s++) begin
      pick = $urandom_range(0, 9);
      k = $urandom_range(0, ENTITIES - 1);
      if (codec_mode == xec_pkg::MODE_DECODE && pick < 5) begin
        for (int i = 0; i < entity_spelling[k].len(); i++) text.push_back(entity_spelling[k][i]);
      end else if (codec_mode == xec_pkg::MODE_DECODE && pick < 7) begin
        cut = $urandom_range(1, entity_spelling[k].len() - 1);
        for (int i = 0; i < cut; i++) text.push_back(entity_spelling[k][i]);
      end else if (codec_mode == xec_pkg::MODE_ENCODE && pick < 5) begin
        text.push_back(entity_glyph[k]);
      end else begin
        text.push_back(8'($urandom_range(1, 255)));
      end
    end
    foreach (text[i]) send_byte(text[i], i == text.size() - 1, 1'b0, '0);
  endtask

  initial begin
    rsp_stall = 1'b0;
    hold_left = 0;
    held_once = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && rsp_valid && !rsp_stall) begin
        if (due_bytes.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected beat %0d: byte %h last %b", beats, rsp_data.out_byte,
                     rsp_data.out_last);
        end else if (rsp_data.out_byte !== due_bytes[0].out_byte ||
                     rsp_data.out_last !== due_bytes[0].out_last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch at beat %0d: byte exp %h got %h, last exp %b got %b", beats,
                     due_bytes[0].out_byte, rsp_data.out_byte, due_bytes[0].out_last,
                     rsp_data.out_last);
        end
        if (due_bytes.size() != 0) void'(due_bytes.pop_front());
        beats++;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_stall <= 1'b1;
      end else if (beats >= HOLD_AT && !held_once) begin
        held_once = 1'b1;
        hold_left = HOLD_CYCLES - 1;
        rsp_stall <= 1'b1;
      end else if (beats >= 120 && beats < 180) begin
        rsp_stall <= 1'b0;
      end else begin
        rsp_stall <= ($urandom_range(99) < 9);
      end
    end
  end

  initial begin
    rst = 1'b1;
    req_valid = 1'b0;
    req_data = '0;
    cfg_valid = 1'b0;
    cfg_data = xec_pkg::MODE_DECODE;
    codec_mode = xec_pkg::MODE_DECODE;
    held_n = 0;
    live_entities = '0;
    items_sent = 0;
    beats = 0;
    mode_writes = 0;
    mismatches = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    foreach (script[r]) begin
      if (script[r].kind == ROW_MODE) write_mode(script[r].b[0]);
      else send_byte(script[r].b, script[r].eos, script[r].typed, script[r].want);
    end
    for (int ph = 0; ph < PHASES; ph++) begin
      int target;
      write_mode(ph[0] ? xec_pkg::MODE_ENCODE : xec_pkg::MODE_DECODE);
      target = items_sent + PHASE_ITEMS;
      while (items_sent < target) send_string();
    end
    wait_idle();
    $display("Ran %0d text bytes through decode and encode, %0d mode writes, %0d output beats.",
             items_sent, mode_writes, beats);
    if (mismatches == 0 && due_bytes.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("FAILURE");
    end
    $finish;
  end

endmodule

FILE: files.f
sv/xec_pkg.sv
sv/xec_core.sv
sv/xec_drain.sv
sv/xml_entity_codec.sv
bench/xml_entity_codec_test.sv
